FILE: rtl/core/prq_pkg.sv
// Shared types and constants for the priority ready queue.
// Used by prq_cell and priority_ready_queue; depends on nothing.
package prq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;

  localparam int ID_W   = 4;
  localparam int PRIO_W = PRIORITY_BITS;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Packed stream widths, padded to whole bytes
  localparam int S_DATA_RAW = ID_W + PRIO_W;
  localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int M_DATA_RAW = ID_W + PRIO_W + 1 + ID_W + CNT_W;
  localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;
  localparam int S_USER_W   = 8;
  localparam int M_USER_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_POP_HEAD  = 2'd1,
    CMD_REMOVE_ID = 2'd2,
    CMD_NOP       = 2'd3
  } prq_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } prq_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } prq_op_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } prq_entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    prq_op_e    op;
    logic       head_rm;
    logic       id_rm;
    prq_entry_t key;
  } prq_ctrl_t;

endpackage

FILE: rtl/core/prq_cell.sv
// One slot of the sorted queue: holds an entry and compares it with the key.
// Depends on prq_pkg; chained by priority_ready_queue.
module prq_cell (
  input  logic                clk_i,
  input  prq_pkg::prq_ctrl_t  ctrl_i,
  input  logic                valid_i,
  input  prq_pkg::prq_entry_t left_i,
  input  prq_pkg::prq_entry_t right_i,
  input  logic                ins_prev_i,
  output logic                ins_o,
  input  logic                rem_prev_i,
  output logic                rem_o,
  input  logic                dup_prev_i,
  output logic                dup_o,
  input  prq_pkg::prq_entry_t rmv_prev_i,
  output prq_pkg::prq_entry_t rmv_o,
  output prq_pkg::prq_entry_t entry_o,
  output prq_pkg::prq_entry_t next_o
);

  prq_pkg::prq_entry_t entry_q, entry_d;
  logic                match;

  // Compare the held entry with the key
  assign match = valid_i && (entry_q.id == ctrl_i.key.id);
  assign ins_o = !valid_i || (ctrl_i.key.prio > entry_q.prio);
  assign rem_o = rem_prev_i || ctrl_i.head_rm || (ctrl_i.id_rm && match);
  assign dup_o = dup_prev_i || match;

  // Pass the removed entry along; only the first removal point adds its own
  assign rmv_o = (rem_o && !rem_prev_i) ? (rmv_prev_i | entry_q) : rmv_prev_i;

  // Shift right to open a gap, or shift left to close one
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      prq_pkg::OP_INSERT: begin
        if (ins_prev_i) begin
          entry_d = left_i;
        end else if (ins_o) begin
          entry_d = ctrl_i.key;
        end
      end
      prq_pkg::OP_REMOVE: begin
        if (rem_o) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign next_o  = entry_d;

endmodule

FILE: rtl/core/priority_ready_queue.sv
// Priority ready queue: a row of slot cells kept in descending priority order.
// Each command word's result word is registered in the output register at acceptance.
// Throughput: one command per cycle while the output register is free or drained;
// the cell row shifts at once, and the remove point is found by a carry chain through all slots.
// Reset clears the entry count and the output valid flag; slot contents are
// not cleared, since only slots below the count are ever read.
// Depends on prq_pkg and prq_cell.
module priority_ready_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: proc_id, new_priority (from the lowest bit up), zero padded
  input  logic [prq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd, zero padded
  input  logic [prq_pkg::S_USER_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: removed_id, removed_priority, head_valid, head_id, queue_count
  output logic [prq_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // tuser: status, zero padded
  output logic [prq_pkg::M_USER_W-1:0]  m_axis_tuser
);

  localparam int D = prq_pkg::QUEUE_DEPTH;

  logic                              accept;
  prq_pkg::prq_cmd_e                 cmd;
  prq_pkg::prq_entry_t               key;
  prq_pkg::prq_ctrl_t                ctrl;
  logic [prq_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              full, empty;
  prq_pkg::prq_status_e              status;
  prq_pkg::prq_entry_t               removed;

  logic                              ins_c [D+1];
  logic                              rem_c [D+1];
  logic                              dup_c [D+1];
  prq_pkg::prq_entry_t               rmv_c [D+1];
  prq_pkg::prq_entry_t               entry [D];
  prq_pkg::prq_entry_t               next  [D];

  logic                              out_valid_q;
  logic [prq_pkg::M_DATA_W-1:0]      out_data_q, out_data_d;
  logic [prq_pkg::M_USER_W-1:0]      out_user_q, out_user_d;

  // Take a word whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Unpack the command word
  assign cmd      = prq_pkg::prq_cmd_e'(s_axis_tuser[prq_pkg::CMD_W-1:0]);
  assign key.id   = s_axis_tdata[prq_pkg::ID_W-1:0];
  assign key.prio = s_axis_tdata[prq_pkg::ID_W +: prq_pkg::PRIO_W];

  assign full  = (count_q == prq_pkg::CNT_W'(D));
  assign empty = (count_q == '0);

  // Decide the operation broadcast to the cells
  always_comb begin
    ctrl.key     = key;
    ctrl.head_rm = (cmd == prq_pkg::CMD_POP_HEAD);
    ctrl.id_rm   = (cmd == prq_pkg::CMD_REMOVE_ID);
    ctrl.op      = prq_pkg::OP_HOLD;
    status       = prq_pkg::ST_OK;
    count_d      = count_q;
    unique case (cmd)
      prq_pkg::CMD_INSERT: begin
        if (full || dup_c[D]) begin
          status = prq_pkg::ST_REJECT;
        end else begin
          ctrl.op = accept ? prq_pkg::OP_INSERT : prq_pkg::OP_HOLD;
          count_d = count_q + 1'b1;
        end
      end
      prq_pkg::CMD_POP_HEAD: begin
        if (empty) begin
          status = prq_pkg::ST_MISS;
        end else begin
          ctrl.op = accept ? prq_pkg::OP_REMOVE : prq_pkg::OP_HOLD;
          count_d = count_q - 1'b1;
        end
      end
      prq_pkg::CMD_REMOVE_ID: begin
        if (!dup_c[D]) begin
          status = prq_pkg::ST_MISS;
        end else begin
          ctrl.op = accept ? prq_pkg::OP_REMOVE : prq_pkg::OP_HOLD;
          count_d = count_q - 1'b1;
        end
      end
      default: ctrl.op = prq_pkg::OP_HOLD;
    endcase
  end

  // Chain ends
  assign ins_c[0] = 1'b0;
  assign rem_c[0] = 1'b0;
  assign dup_c[0] = 1'b0;
  assign rmv_c[0] = '0;

  // Row of slot cells, head at slot 0
  for (genvar i = 0; i < D; i++) begin : g_cell
    prq_pkg::prq_entry_t left, right;
    logic                valid;

    assign valid = (prq_pkg::CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      assign left = key;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_r
      assign right = entry[i+1];
    end

    prq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (valid),
      .left_i     (left),
      .right_i    (right),
      .ins_prev_i (ins_c[i]),
      .ins_o      (ins_c[i+1]),
      .rem_prev_i (rem_c[i]),
      .rem_o      (rem_c[i+1]),
      .dup_prev_i (dup_c[i]),
      .dup_o      (dup_c[i+1]),
      .rmv_prev_i (rmv_c[i]),
      .rmv_o      (rmv_c[i+1]),
      .entry_o    (entry[i]),
      .next_o     (next[i])
    );
  end

  // Report the removed entry only for a remove that took place
  assign removed = ((cmd == prq_pkg::CMD_POP_HEAD || cmd == prq_pkg::CMD_REMOVE_ID)
                    && status == prq_pkg::ST_OK) ? rmv_c[D] : '0;

  // Pack the result word
  always_comb begin
    out_data_d = '0;
    out_data_d[prq_pkg::M_DATA_RAW-1:0] =
      {count_d,
       (count_d != '0) ? next[0].id : {prq_pkg::ID_W{1'b0}},
       (count_d != '0),
       removed.prio,
       removed.id};
    out_user_d = '0;
    out_user_d[prq_pkg::STAT_W-1:0] = status;
  end

  // Hold count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

FILE: tb/priority_ready_queue_tb.sv
// Self-checking testbench for priority_ready_queue: drives command words, predicts
// each report word from a shadow of the sorted ready queue and checks it field by field.
// Depends on prq_pkg and the priority_ready_queue RTL.
module priority_ready_queue_tb;

  // Report word layout, from the lowest bit of m_axis_tdata up
  localparam int RID_LO  = 0;
  localparam int RPR_LO  = RID_LO + prq_pkg::ID_W;
  localparam int HV_BIT  = RPR_LO + prq_pkg::PRIO_W;
  localparam int HID_LO  = HV_BIT + 1;
  localparam int CNT_LO  = HID_LO + prq_pkg::ID_W;
  localparam int N_RAND  = 1700;

  typedef struct {
    prq_pkg::prq_cmd_e          cmd;
    logic [prq_pkg::ID_W-1:0]   id;
    logic [prq_pkg::PRIO_W-1:0] prio;
    int                         phase;
    bit                         drain;
  } cmd_word_t;

  typedef struct packed {
    prq_pkg::prq_status_e       status;
    logic [prq_pkg::ID_W-1:0]   removed_id;
    logic [prq_pkg::PRIO_W-1:0] removed_prio;
    logic                       head_valid;
    logic [prq_pkg::ID_W-1:0]   head_id;
    logic [prq_pkg::CNT_W-1:0]  count;
  } queue_report_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // tdata: proc_id, new_priority (from the lowest bit up), zero padded
  logic [prq_pkg::S_DATA_W-1:0]  s_axis_tdata;
  // tuser: cmd, zero padded
  logic [prq_pkg::S_USER_W-1:0]  s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // tdata: removed_id, removed_priority, head_valid, head_id, queue_count
  logic [prq_pkg::M_DATA_W-1:0]  m_axis_tdata;
  // tuser: status, zero padded
  logic [prq_pkg::M_USER_W-1:0]  m_axis_tuser;

  cmd_word_t           pending_cmds[$];
  queue_report_t       awaited_reports[$];
  prq_pkg::prq_entry_t ready_q[$];
  int                  mismatch_cnt;
  int                  load_phase;
  logic                cmd_taken;

  priority_ready_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock: 20 units per period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one command to the shadow queue and return the report it gives
  function automatic queue_report_t next_queue_report(
    prq_pkg::prq_cmd_e c, logic [prq_pkg::ID_W-1:0] id, logic [prq_pkg::PRIO_W-1:0] prio);
    queue_report_t       rep;
    prq_pkg::prq_entry_t ent;
    int                  pos;
    int                  at;
    rep = '0;
    pos = -1;
    for (int i = 0; i < ready_q.size(); i++) begin
      if (ready_q[i].id == id && pos < 0) pos = i;
    end
    case (c)
      prq_pkg::CMD_INSERT: begin
        if (ready_q.size() >= prq_pkg::QUEUE_DEPTH || pos >= 0) begin
          rep.status = prq_pkg::ST_REJECT;
        end else begin
          // go in front of the first entry of strictly lower priority
          at = ready_q.size();
          for (int i = ready_q.size() - 1; i >= 0; i--) begin
            if (prio > ready_q[i].prio) at = i;
          end
          ent.id   = id;
          ent.prio = prio;
          ready_q.insert(at, ent);
        end
      end
      prq_pkg::CMD_POP_HEAD: begin
        if (ready_q.size() == 0) begin
          rep.status = prq_pkg::ST_MISS;
        end else begin
          rep.removed_id   = ready_q[0].id;
          rep.removed_prio = ready_q[0].prio;
          ready_q.delete(0);
        end
      end
      prq_pkg::CMD_REMOVE_ID: begin
        if (pos < 0) begin
          rep.status = prq_pkg::ST_MISS;
        end else begin
          rep.removed_id   = ready_q[pos].id;
          rep.removed_prio = ready_q[pos].prio;
          ready_q.delete(pos);
        end
      end
      default: ;
    endcase
    rep.head_valid = (ready_q.size() != 0);
    rep.head_id    = (ready_q.size() != 0) ? ready_q[0].id : '0;
    rep.count      = prq_pkg::CNT_W'(ready_q.size());
    return rep;
  endfunction

  task automatic queue_cmd(prq_pkg::prq_cmd_e c, int id, int prio, int phase, bit drain);
    cmd_word_t w;
    w.cmd   = c;
    w.id    = prq_pkg::ID_W'(id);
    w.prio  = prq_pkg::PRIO_W'(prio);
    w.phase = phase;
    w.drain = drain;
    pending_cmds.push_back(w);
  endtask

  // Driver: present command words and the receiver's ready at the falling edge
  always @(negedge clk_i) begin : drive_cmds
    cmd_word_t nxt;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >=
                        ((load_phase == 0) ? 49 : (load_phase == 1) ? 27 : 0));
      if (!s_axis_tvalid || cmd_taken) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].drain && awaited_reports.size() != 0) &&
            $urandom_range(99) >= ((pending_cmds[0].phase == 0) ? 27 :
                                   (pending_cmds[0].phase == 1) ? 49 : 0)) begin
          nxt = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(prq_pkg::S_DATA_W - prq_pkg::ID_W - prq_pkg::PRIO_W){1'b0}},
                            nxt.prio, nxt.id};
          s_axis_tuser  <= {{(prq_pkg::S_USER_W - prq_pkg::CMD_W){1'b0}}, nxt.cmd};
          load_phase    <= nxt.phase;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check report words, predict from accepted command words
  always @(posedge clk_i) begin : watch_ports
    queue_report_t want;
    queue_report_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = prq_pkg::prq_status_e'(m_axis_tuser[prq_pkg::STAT_W-1:0]);
        got.removed_id   = m_axis_tdata[RID_LO +: prq_pkg::ID_W];
        got.removed_prio = m_axis_tdata[RPR_LO +: prq_pkg::PRIO_W];
        got.head_valid   = m_axis_tdata[HV_BIT];
        got.head_id      = m_axis_tdata[HID_LO +: prq_pkg::ID_W];
        got.count        = m_axis_tdata[CNT_LO +: prq_pkg::CNT_W];
        if (awaited_reports.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected report word: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
        end else begin
          want = awaited_reports.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("report differs (expected/actual): status %0d/%0d rid %0d/%0d",
                       want.status, got.status, want.removed_id, got.removed_id);
              $display("  rprio %0d/%0d hv %0d/%0d hid %0d/%0d count %0d/%0d",
                       want.removed_prio, got.removed_prio, want.head_valid,
                       got.head_valid, want.head_id, got.head_id, want.count, got.count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_reports.push_back(next_queue_report(
          prq_pkg::prq_cmd_e'(s_axis_tuser[prq_pkg::CMD_W-1:0]),
          s_axis_tdata[prq_pkg::ID_W-1:0],
          s_axis_tdata[prq_pkg::ID_W +: prq_pkg::PRIO_W]));
      cmd_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_test
    int                fill_bias;
    int                ph;
    int                pr;
    prq_pkg::prq_cmd_e c;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    mismatch_cnt  = 0;
    load_phase    = 0;
    cmd_taken     = 1'b0;

    // empty queue: pop head and remove id both miss; unused code does nothing
    queue_cmd(prq_pkg::CMD_POP_HEAD, 0, 0, 0, 0);
    queue_cmd(prq_pkg::CMD_REMOVE_ID, 3, 0, 0, 0);
    queue_cmd(prq_pkg::CMD_NOP, 15, 255, 0, 0);
    // priority extremes and ties at both ends
    queue_cmd(prq_pkg::CMD_INSERT, 0, 0, 0, 0);
    queue_cmd(prq_pkg::CMD_INSERT, 15, 255, 0, 0);
    queue_cmd(prq_pkg::CMD_INSERT, 5, 255, 0, 0);
    queue_cmd(prq_pkg::CMD_INSERT, 7, 0, 0, 0);
    // duplicate id rejected, unknown id misses
    queue_cmd(prq_pkg::CMD_INSERT, 5, 100, 0, 0);
    queue_cmd(prq_pkg::CMD_REMOVE_ID, 9, 0, 0, 0);
    // fill to the last slot
    for (int id = 1; id < 16; id++) begin
      if (id != 5 && id != 7 && id != 15)
        queue_cmd(prq_pkg::CMD_INSERT, id, $urandom_range(255), 0, 0);
    end
    // insert into a full queue
    queue_cmd(prq_pkg::CMD_INSERT, 9, 128, 0, 0);
    queue_cmd(prq_pkg::CMD_POP_HEAD, 0, 0, 0, 0);
    queue_cmd(prq_pkg::CMD_REMOVE_ID, 0, 0, 0, 0);
    queue_cmd(prq_pkg::CMD_REMOVE_ID, 7, 0, 0, 0);

    // random traffic, swinging between filling and draining
    fill_bias = 50;
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 60 == 0) fill_bias = $urandom_range(20, 80);
      ph = n * 3 / N_RAND;
      if ($urandom_range(99) < 5)
        c = prq_pkg::CMD_NOP;
      else if ($urandom_range(99) < fill_bias)
        c = prq_pkg::CMD_INSERT;
      else if ($urandom_range(1) == 0)
        c = prq_pkg::CMD_POP_HEAD;
      else
        c = prq_pkg::CMD_REMOVE_ID;
      // favor a few shared priorities so ties come up often
      pr = ($urandom_range(2) == 0) ? $urandom_range(3) * 85 : $urandom_range(255);
      queue_cmd(c, $urandom_range(15), pr, ph, (n % 250) == 249);
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for every command word to go in and every report word to come out
    while (pending_cmds.size() != 0 || s_axis_tvalid || awaited_reports.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("priority_ready_queue: match");
    end else begin
      $display("priority_ready_queue: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(20 * 200000);
    $display("priority_ready_queue: mismatch");
    $finish;
  end

endmodule

FILE: priority_ready_queue.f
rtl/core/prq_pkg.sv
rtl/core/prq_cell.sv
rtl/core/priority_ready_queue.sv
tb/priority_ready_queue_tb.sv
